@@ rtl/fir_filter_sample_macros.svh @@
// assertion helpers shared by the fir filter rtl
`ifndef FIR_FILTER_SAMPLE_MACROS_SVH
`define FIR_FILTER_SAMPLE_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define FIR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every clock edge outside reset
`define FIR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/fir_pkg.sv @@
`default_nettype none

package fir_pkg;

   // item field widths
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int PROD_W   = 32;
   localparam int RESULT_W = 32;

   // coefficient register file
   localparam int NUM_GROUPS     = 8;
   localparam int GROUP_IDX_W    = 3;
   localparam int TAPS_PER_GROUP = 4;
   localparam int CSR_INDEX_W    = 4;
   localparam int CSR_DATA_W     = 64;

   // tap count range
   localparam int MAX_TAPS     = 32;
   localparam int DEFAULT_TAPS = 32;

   // control shared by every cell of the chain
   typedef struct packed {
      logic shift;    // take a new sample into the delay line
      logic advance;  // move the partial sum one cell on
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/fir_cell.sv @@
`default_nettype none

module fir_cell #(
   parameter int SUM_W = fir_pkg::PROD_W + $clog2(fir_pkg::DEFAULT_TAPS)
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire fir_pkg::cell_ctrl_type            ctrl,
   input  wire logic signed [fir_pkg::SAMPLE_W-1:0] sample_in,
   input  wire logic signed [fir_pkg::COEF_W-1:0]   coef,
   input  wire logic                              link_valid_in,
   input  wire logic signed [SUM_W-1:0]           link_sum_in,
   output logic signed [fir_pkg::SAMPLE_W-1:0]    sample_out,
   output logic                                   link_valid_out,
   output logic signed [SUM_W-1:0]                link_sum_out
);

   logic signed [fir_pkg::SAMPLE_W-1:0] sample_ff;
   logic                                valid_ff;
   logic signed [SUM_W-1:0]             sum_ff;
   logic signed [SUM_W-1:0]             sum_in;
   logic signed [fir_pkg::PROD_W-1:0]   prod;

   // tap product added to the partial sum from the previous cell
   always_comb begin
      prod   = coef * sample_ff;
      sum_in = link_sum_in + SUM_W'(prod);
   end

   // delay line slot, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (ctrl.shift) begin
         sample_ff <= sample_in;
      end
   end

   // partial sum token
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         valid_ff <= link_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance && link_valid_in) begin
         sum_ff <= sum_in;
      end
   end

   assign sample_out     = sample_ff;
   assign link_valid_out = valid_ff;
   assign link_sum_out   = sum_ff;

endmodule

`default_nettype wire

@@ rtl/fir_filter_sample.sv @@
`default_nettype none
// channel  direction  handshake               payload
// req      in         req_valid / req_stall   req_sample_in
// rsp      out        rsp_valid / rsp_stall   rsp_filtered_sum, rsp_sum_overflowed
// csr      in         csr_valid / csr_ready   csr_index, csr_data
//
// after acceptance an item's sum token starts in the go flag:
// the partial sum walks through the TAPS cells one cell per cycle, then lands in
// the output register. reset clears the sample delay line and the coefficients.
// while a result is stalled the chain holds its token, and a new item is taken
// only once the previous sum has reached the output register.
// csr_ready is always high.

`include "fir_filter_sample_macros.svh"

module fir_filter_sample #(
   parameter int TAPS = fir_pkg::DEFAULT_TAPS
) (
   input  wire                                        clock,
   input  wire                                        reset,
   // input samples
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [fir_pkg::SAMPLE_W-1:0]   req_sample_in,
   // filter results
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [fir_pkg::RESULT_W-1:0]        rsp_filtered_sum,
   output logic                                       rsp_sum_overflowed,
   // coefficient writes
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [fir_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [fir_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int SUM_W = fir_pkg::PROD_W + $clog2(TAPS);

   logic [fir_pkg::CSR_DATA_W-1:0]        coef_ff [fir_pkg::NUM_GROUPS];
   logic                                  running_ff;
   logic                                  running_in;
   logic                                  go_ff;
   logic                                  go_in;
   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   logic signed [fir_pkg::RESULT_W-1:0]   sum_out_ff;
   logic                                  ovf_out_ff;

   logic                                  req_accept;
   logic                                  load;
   logic                                  tail_valid;
   logic signed [SUM_W-1:0]               tail_sum;
   logic [SUM_W-1:32-1]                   tail_top;
   fir_pkg::cell_ctrl_type                ctrl;

   logic signed [fir_pkg::SAMPLE_W-1:0]   samp   [TAPS];
   logic                                  cvalid [TAPS];
   logic signed [SUM_W-1:0]               csum   [TAPS];
   logic [TAPS:0]                         token_vec;

   // coefficient registers, writes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < fir_pkg::NUM_GROUPS; g++) begin
            coef_ff[g] <= '0;
         end
      end else if (csr_valid && csr_ready &&
                   (csr_index < fir_pkg::CSR_INDEX_W'(fir_pkg::NUM_GROUPS))) begin
         coef_ff[csr_index[fir_pkg::GROUP_IDX_W-1:0]] <= csr_data;
      end
   end

   assign csr_ready = 1'b1;

   // chain control
   always_comb begin
      req_accept   = req_valid && !req_stall;
      tail_valid   = cvalid[TAPS-1];
      tail_sum     = csum[TAPS-1];
      load         = tail_valid && (!rsp_valid_ff || !rsp_stall);
      ctrl.shift   = req_accept;
      ctrl.advance = !tail_valid || load;
      go_in        = req_accept ? 1'b1 : (ctrl.advance ? 1'b0 : go_ff);
      running_in   = req_accept ? 1'b1 : (load ? 1'b0 : running_ff);
      rsp_valid_in = load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         running_ff   <= running_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // row of tap cells: samples shift on accept, partial sum moves each cycle unless the result is stalled
   for (genvar k = 0; k < TAPS; k++) begin : g_cell
      logic signed [fir_pkg::SAMPLE_W-1:0] cell_sample_in;
      logic                                cell_valid_in;
      logic signed [SUM_W-1:0]             cell_sum_in;
      logic signed [fir_pkg::COEF_W-1:0]   cell_coef;

      if (k == 0) begin : g_head
         assign cell_sample_in = req_sample_in;
         assign cell_valid_in  = go_ff;
         assign cell_sum_in    = '0;
      end else begin : g_body
         assign cell_sample_in = samp[k-1];
         assign cell_valid_in  = cvalid[k-1];
         assign cell_sum_in    = csum[k-1];
      end

      assign cell_coef = coef_ff[k / fir_pkg::TAPS_PER_GROUP]
                        [(k % fir_pkg::TAPS_PER_GROUP) * fir_pkg::COEF_W +: fir_pkg::COEF_W];

      fir_cell #(
         .SUM_W (SUM_W)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (ctrl),
         .sample_in      (cell_sample_in),
         .coef           (cell_coef),
         .link_valid_in  (cell_valid_in),
         .link_sum_in    (cell_sum_in),
         .sample_out     (samp[k]),
         .link_valid_out (cvalid[k]),
         .link_sum_out   (csum[k])
      );

      assign token_vec[k] = cvalid[k];
   end

   assign token_vec[TAPS] = go_ff;

   // output register, overflow when the bits above bit 31 disagree with it
   assign tail_top = tail_sum[SUM_W-1:32-1];

   always_ff @(posedge clock) begin
      if (load) begin
         sum_out_ff <= tail_sum[fir_pkg::RESULT_W-1:0];
         ovf_out_ff <= !((&tail_top) || !(|tail_top));
      end
   end

   assign req_stall          = running_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_sum   = sum_out_ff;
   assign rsp_sum_overflowed = ovf_out_ff;

   // checks on the sum token and the control around it
   `FIR_ASSERT_NOW(a_one_token, 1'b1, $onehot0(token_vec), "more than one sum in the chain")
   `FIR_ASSERT_NOW(a_idle_empty, !running_ff, !go_ff && !tail_valid, "token without item")
   `FIR_ASSERT_NEXT(a_accept_go, req_accept, go_ff && running_ff, "accepted item not started")
   `FIR_ASSERT_NEXT(a_load_valid, load, rsp_valid_ff && !running_ff, "result not presented")

endmodule

`default_nettype wire

@@ sim/fir_filter_sample_checker.sv @@
`default_nettype none

module fir_filter_sample_checker #(
   parameter int TAPS = fir_pkg::DEFAULT_TAPS
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_stall,
   input  wire logic signed [fir_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   input  wire logic signed [fir_pkg::RESULT_W-1:0]  rsp_filtered_sum,
   input  wire logic                                 rsp_sum_overflowed,
   input  wire logic                                 csr_valid,
   input  wire logic                                 csr_ready,
   input  wire logic [fir_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [fir_pkg::CSR_DATA_W-1:0]       csr_data,
   output int                                        mismatch_count,
   output int                                        sums_in_flight
);

   typedef struct packed {
      logic signed [fir_pkg::RESULT_W-1:0] total;
      logic                                overflow;
   } fir_result_type;

   logic [fir_pkg::CSR_DATA_W-1:0]      coef_groups [fir_pkg::NUM_GROUPS];
   logic signed [fir_pkg::SAMPLE_W-1:0] sample_history [fir_pkg::MAX_TAPS-1];
   fir_result_type                      expected_sums [$];

   // exact convolution over the newest sample and the delay line
   function automatic fir_result_type convolve_sample(
      input logic signed [fir_pkg::SAMPLE_W-1:0] x);
      logic signed [63:0]                  acc;
      logic signed [fir_pkg::COEF_W-1:0]   tap;
      logic signed [fir_pkg::SAMPLE_W-1:0] smp;
      fir_result_type                      res;
      acc = '0;
      for (int k = 0; k < TAPS; k++) begin
         tap = coef_groups[k / fir_pkg::TAPS_PER_GROUP]
                          [fir_pkg::COEF_W * (k % fir_pkg::TAPS_PER_GROUP) +: fir_pkg::COEF_W];
         smp = (k == 0) ? x : sample_history[k - 1];
         acc = acc + tap * smp;
      end
      res.total    = acc[fir_pkg::RESULT_W-1:0];
      // the exact sum fits only if sign extending the low word gives it back
      res.overflow = (acc != {{(64 - fir_pkg::RESULT_W){acc[fir_pkg::RESULT_W-1]}},
                              acc[fir_pkg::RESULT_W-1:0]});
      return res;
   endfunction

   always @(posedge clock) begin
      fir_result_type want;
      if (reset) begin
         foreach (coef_groups[g]) coef_groups[g] = '0;
         foreach (sample_history[i]) sample_history[i] = '0;
         expected_sums.delete();
      end else begin
         // compare an accepted result with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_sums.size() == 0) begin
               $display("%0t unexpected result: expected none, actual sum %0d overflow %0b",
                        $time, rsp_filtered_sum, rsp_sum_overflowed);
               mismatch_count++;
            end else begin
               want = expected_sums.pop_front();
               if (rsp_filtered_sum !== want.total) begin
                  $display("%0t filtered_sum mismatch: expected %0d actual %0d",
                           $time, want.total, rsp_filtered_sum);
                  mismatch_count++;
               end
               if (rsp_sum_overflowed !== want.overflow) begin
                  $display("%0t sum_overflowed mismatch: expected %0b actual %0b",
                           $time, want.overflow, rsp_sum_overflowed);
                  mismatch_count++;
               end
            end
         end
         // coefficient writes, indexes past the last group are dropped
         if (csr_valid && csr_ready && csr_index < fir_pkg::NUM_GROUPS)
            coef_groups[csr_index[fir_pkg::GROUP_IDX_W-1:0]] = csr_data;
         // predict the item just taken, then shift it into the delay line
         if (req_valid && !req_stall) begin
            expected_sums.push_back(convolve_sample(req_sample_in));
            for (int i = fir_pkg::MAX_TAPS - 2; i > 0; i--)
               sample_history[i] = sample_history[i - 1];
            sample_history[0] = req_sample_in;
         end
      end
      sums_in_flight = expected_sums.size();
   end

endmodule

`default_nettype wire

@@ sim/fir_filter_sample_tb.sv @@
`default_nettype none

module fir_filter_sample_tb;

   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 140;
   localparam int IDLE_PHASES     = 8;
   localparam logic [fir_pkg::CSR_INDEX_W-1:0] FIRST_GROUP_INDEX = '0;
   localparam logic [fir_pkg::CSR_INDEX_W-1:0] FIRST_BAD_INDEX =
      fir_pkg::CSR_INDEX_W'(fir_pkg::NUM_GROUPS);
   localparam logic [fir_pkg::CSR_INDEX_W-1:0] LAST_BAD_INDEX  = '1;
   localparam logic [fir_pkg::COEF_W-1:0] COEF_MAX = 16'h7FFF;
   localparam logic [fir_pkg::COEF_W-1:0] COEF_MIN = 16'h8000;
   localparam logic signed [fir_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [fir_pkg::SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic signed [fir_pkg::SAMPLE_W-1:0]  req_sample_in = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic signed [fir_pkg::RESULT_W-1:0]  rsp_filtered_sum;
   logic                                 rsp_sum_overflowed;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [fir_pkg::CSR_INDEX_W-1:0]      csr_index = '0;
   logic [fir_pkg::CSR_DATA_W-1:0]       csr_data = '0;

   bit req_gaps_on   = 1'b0;
   bit rsp_stalls_on = 1'b0;
   int mismatch_count;
   int sums_in_flight;

   always #2 clock = ~clock;

   fir_filter_sample DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_in      (req_sample_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_sum   (rsp_filtered_sum),
      .rsp_sum_overflowed (rsp_sum_overflowed),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   fir_filter_sample_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_in      (req_sample_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_sum   (rsp_filtered_sum),
      .rsp_sum_overflowed (rsp_sum_overflowed),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatch_count     (mismatch_count),
      .sums_in_flight     (sums_in_flight)
   );

   // offer one sample, with an occasional random gap first
   task automatic send_sample(input logic signed [fir_pkg::SAMPLE_W-1:0] x);
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_sample_in <= fir_pkg::SAMPLE_W'($urandom);
         repeat ($urandom_range(0, 13)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_sample_in <= x;
      do @(posedge clock); while (req_stall);
   endtask

   // stop offering and wait until every predicted sum has come back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sums_in_flight != 0) @(negedge clock);
   endtask

   task automatic write_coef_group(input logic [fir_pkg::CSR_INDEX_W-1:0] idx,
                                   input logic [fir_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_all_taps(input logic [fir_pkg::COEF_W-1:0] tap);
      for (int g = 0; g < fir_pkg::NUM_GROUPS; g++)
         write_coef_group(fir_pkg::CSR_INDEX_W'(g), {fir_pkg::TAPS_PER_GROUP{tap}});
   endtask

   // result side stalls in random bursts
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_stalls_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 13)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic [fir_pkg::CSR_DATA_W-1:0]      group_word;
      logic [fir_pkg::COEF_W-1:0]          lane;
      logic [fir_pkg::COEF_W-1:0]          shared_tap;
      logic signed [fir_pkg::SAMPLE_W-1:0] x;
      int                                  active_taps;
      int                                  coef_mode;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // zero coefficients after reset: extremes only fill the delay line
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      drain_results();

      // every tap at the most negative value, samples at both extremes
      load_all_taps(COEF_MIN);
      repeat (3) send_sample(SAMPLE_MIN);
      repeat (3) send_sample(SAMPLE_MAX);
      drain_results();

      // every tap at the most positive value, pushing toward negative overflow
      load_all_taps(COEF_MAX);
      repeat (4) send_sample(SAMPLE_MIN);
      send_sample(16'sd0);
      send_sample(16'sd1);
      send_sample(-16'sd1);
      drain_results();

      // writes past the last group must leave the coefficients alone
      write_coef_group(FIRST_BAD_INDEX, '1);
      write_coef_group(LAST_BAD_INDEX, '1);
      write_coef_group(FIRST_GROUP_INDEX, 64'h0001_FFFF_7FFF_8000);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      drain_results();

      // random phases, each with its own coefficient set
      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         coef_mode   = p % 5;
         active_taps = $urandom_range(1, fir_pkg::MAX_TAPS);
         shared_tap  = fir_pkg::COEF_W'($urandom);
         for (int g = 0; g < fir_pkg::NUM_GROUPS; g++) begin
            for (int j = 0; j < fir_pkg::TAPS_PER_GROUP; j++) begin
               case (coef_mode)
                  0: lane = fir_pkg::COEF_W'($urandom);
                  1: begin
                     case ($urandom_range(0, 3))
                        0: lane = COEF_MAX;
                        1: lane = COEF_MIN;
                        2: lane = '0;
                        default: lane = '1;
                     endcase
                  end
                  // shorter filter: upper taps zeroed
                  2: lane = (g * fir_pkg::TAPS_PER_GROUP + j < active_taps) ?
                            fir_pkg::COEF_W'($urandom) : '0;
                  3: lane = fir_pkg::COEF_W'($urandom_range(0, 8)) - fir_pkg::COEF_W'(4);
                  default: lane = shared_tap;
               endcase
               group_word[fir_pkg::COEF_W * j +: fir_pkg::COEF_W] = lane;
            end
            write_coef_group(fir_pkg::CSR_INDEX_W'(g), group_word);
         end
         if ($urandom_range(0, 1) == 0)
            write_coef_group(fir_pkg::CSR_INDEX_W'($urandom_range(FIRST_BAD_INDEX,
                                                                  LAST_BAD_INDEX)),
                             {$urandom, $urandom});

         // idling off for a couple of phases midway and for the tail
         req_gaps_on   = (p < IDLE_PHASES) && (p != 3);
         rsp_stalls_on = (p < IDLE_PHASES) && (p != 5);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            case ($urandom_range(0, 3))
               0: begin
                  case ($urandom_range(0, 3))
                     0: x = SAMPLE_MAX;
                     1: x = SAMPLE_MIN;
                     2: x = '0;
                     default: x = -16'sd1;
                  endcase
               end
               1: x = fir_pkg::SAMPLE_W'($urandom_range(0, 16)) - fir_pkg::SAMPLE_W'(8);
               default: x = fir_pkg::SAMPLE_W'($urandom);
            endcase
            send_sample(x);
         end
      end

      drain_results();
      repeat (fir_pkg::MAX_TAPS + 8) @(negedge clock);
      if (mismatch_count == 0 && sums_in_flight == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/fir_pkg.sv
rtl/fir_cell.sv
rtl/fir_filter_sample.sv
sim/fir_filter_sample_checker.sv
sim/fir_filter_sample_tb.sv
